[sv/mbgl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbgl_pkg
// Shared constants, types and table functions for the master balance, gain
// and soft limiter block.
// ----------------------------------------------------------------------------
package mbgl_pkg;

    localparam int DEF_SAMPLE_BITS     = 24;
    localparam int DEF_TANH_TABLE_SIZE = 256;

    localparam int GAIN_W     = 16;
    localparam int BAL_W      = 17;
    localparam int BALF_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int TANH_W     = 24;
    localparam int FRAC_W     = 16;
    localparam int SCALE_SHIFT = 27;   // Q4.12 gain times Q1.15 balance
    localparam int FIFO_DEPTH = 4;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;
    localparam logic [BALF_W-1:0] BAL_UNITY  = 16'd32768;
    localparam logic signed [BAL_W-1:0] BAL_MAX = 17'sd32768;
    localparam logic signed [BAL_W-1:0] BAL_MIN = -17'sd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASTER_GAIN     = 2'd0,
        CFG_MASTER_BALANCE  = 2'd1,
        CFG_LIMITER_CEILING = 2'd2
    } cfg_idx_e;

    // per-frame scaling shared by both channels
    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [BALF_W-1:0] bal_l;
        logic [BALF_W-1:0] bal_r;
    } scale_t;

    localparam logic [63:0] Q30_ONE = 64'd1073741824;

    // shift-subtract division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], n[b]};
            if (r >= d)
            begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(8*i/size) in Q0.23
    function automatic logic [TANH_W-1:0] tanh_entry(input logic [63:0] i,
                                                     input logic [63:0] size);
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] num;
        z    = udiv64((i << 30) + size * 64'd32, size * 64'd64);
        term = Q30_ONE;
        e    = Q30_ONE;
        for (int k = 1; k <= 5; k++)
        begin
            term = udiv64((term * z) >> 30, 64'(k));
            if (k[0])
                e = e - term;
            else
                e = e + term;
        end
        for (int k = 0; k < 10; k++)
            e = (e * e + (Q30_ONE >> 1)) >> 30;
        den = Q30_ONE + e;
        num = (Q30_ONE - e) << 23;
        return TANH_W'(udiv64(num + (den >> 1), den));
    endfunction

endpackage
`default_nettype wire

[sv/mbgl_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbgl_in_if / mbgl_out_if
// Stereo frame channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mbgl_in_if #(parameter int W = 24);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] left_in;
    logic signed [W-1:0] right_in;
    logic                block_last;

    modport source (output valid, left_in, right_in, block_last, input ready);
    modport sink   (input valid, left_in, right_in, block_last, output ready);
endinterface

interface mbgl_out_if #(parameter int W = 24);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] left_out;
    logic signed [W-1:0] right_out;
    logic                block_last_out;

    modport source (output valid, left_out, right_out, block_last_out, input ready);
    modport sink   (input valid, left_out, right_out, block_last_out, output ready);
endinterface
`default_nettype wire

[sv/mbgl_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbgl_front
// Accepts frames, takes magnitudes, applies gain and balance, derives knee.
// ----------------------------------------------------------------------------
module mbgl_front
    import mbgl_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int CW = SAMPLE_BITS - 1,
    localparam int MW = SAMPLE_BITS + 6,
    localparam int PW = 2 * (MW + 1) + 1 + 3 * CW
)(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [SAMPLE_BITS-1:0] left,
    input  wire logic [SAMPLE_BITS-1:0] right,
    input  wire logic                   last,
    input  wire scale_t                 scale,
    input  wire logic [CW-1:0]          ceiling,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [PW-1:0]               out_data
);

    localparam int SB  = SAMPLE_BITS;
    localparam int P1W = SB + GAIN_W;
    localparam int P2W = P1W + BALF_W;
    localparam int KS  = SB + 3;                       // reciprocal shift
    localparam logic [63:0] KM64 = ((64'd1 << KS) + 64'd4) / 64'd5;
    localparam int KMW = KS - 1;
    localparam int KPW = SB + 1 + KMW;
    localparam logic [KMW-1:0] KM = KMW'(KM64);

    logic v1_reg, v2_reg, v3_reg;
    logic adv;

    logic            negl1_reg, negr1_reg, last1_reg;
    logic [P1W-1:0]  pl1_reg, pr1_reg;
    logic [KPW-1:0]  kp1_reg;
    logic [CW-1:0]   c1_reg;
    logic [BALF_W-1:0] bl1_reg, br1_reg;

    logic            negl2_reg, negr2_reg, last2_reg;
    logic [P2W-1:0]  pl2_reg, pr2_reg;
    logic [CW-1:0]   knee2_reg, span2_reg, c2_reg;

    logic            negl3_reg, negr3_reg, last3_reg;
    logic [MW-1:0]   ml3_reg, mr3_reg;
    logic [CW-1:0]   knee3_reg, span3_reg, c3_reg;

    logic [SB-1:0]   abs_l, abs_r;
    logic [CW-1:0]   knee_c;
    logic [P2W:0]    rl, rr;

    assign adv      = !v3_reg || out_ready;
    assign in_ready = adv;

    assign abs_l  = left[SB-1]  ? SB'(-left)  : left;
    assign abs_r  = right[SB-1] ? SB'(-right) : right;
    assign knee_c = CW'(kp1_reg >> KS);
    assign rl     = {1'b0, pl2_reg} + (P2W+1)'(64'd1 << (SCALE_SHIFT - 1));
    assign rr     = {1'b0, pr2_reg} + (P2W+1)'(64'd1 << (SCALE_SHIFT - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            negl1_reg <= left[SB-1];
            negr1_reg <= right[SB-1];
            last1_reg <= last;
            pl1_reg   <= P1W'(abs_l) * P1W'(scale.gain);
            pr1_reg   <= P1W'(abs_r) * P1W'(scale.gain);
            kp1_reg   <= KPW'({ceiling, 2'b00}) * KPW'(KM);
            c1_reg    <= ceiling;
            bl1_reg   <= scale.bal_l;
            br1_reg   <= scale.bal_r;

            negl2_reg <= negl1_reg;
            negr2_reg <= negr1_reg;
            last2_reg <= last1_reg;
            pl2_reg   <= P2W'(pl1_reg) * P2W'(bl1_reg);
            pr2_reg   <= P2W'(pr1_reg) * P2W'(br1_reg);
            knee2_reg <= knee_c;
            span2_reg <= c1_reg - knee_c;
            c2_reg    <= c1_reg;

            negl3_reg <= negl2_reg;
            negr3_reg <= negr2_reg;
            last3_reg <= last2_reg;
            ml3_reg   <= rl[P2W:SCALE_SHIFT];
            mr3_reg   <= rr[P2W:SCALE_SHIFT];
            knee3_reg <= knee2_reg;
            span3_reg <= span2_reg;
            c3_reg    <= c2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = {last3_reg, negl3_reg, ml3_reg, negr3_reg, mr3_reg,
                        knee3_reg, span3_reg, c3_reg};

endmodule
`default_nettype wire

[sv/mbgl_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbgl_fifo
// Short register queue between front and back.
// ----------------------------------------------------------------------------
module mbgl_fifo
    import mbgl_pkg::*;
#(
    parameter int W = 8
)(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr_valid,
    output logic              wr_ready,
    input  wire logic [W-1:0] wr_data,
    output logic              rd_valid,
    input  wire logic         rd_ready,
    output logic [W-1:0]      rd_data
);

    localparam int AW = $clog2(FIFO_DEPTH);

    logic [W-1:0]  mem_reg [FIFO_DEPTH];
    logic [AW-1:0] wptr_reg, rptr_reg;
    logic [AW:0]   cnt_reg;
    logic          wr_en, rd_en;

    assign wr_ready = cnt_reg != (AW+1)'(FIFO_DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wptr_reg <= wptr_reg + 1'b1;
            if (rd_en)
                rptr_reg <= rptr_reg + 1'b1;
            if (wr_en && !rd_en)
                cnt_reg <= cnt_reg + 1'b1;
            else if (rd_en && !wr_en)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wptr_reg] <= wr_data;
    end

endmodule
`default_nettype wire

[sv/mbgl_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbgl_lane
// Soft knee limiter pipeline for one channel: divider, tanh table, shaping.
// ----------------------------------------------------------------------------
module mbgl_lane
    import mbgl_pkg::*;
#(
    parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
    parameter int TANH_TABLE_SIZE = DEF_TANH_TABLE_SIZE,
    localparam int CW = SAMPLE_BITS - 1,
    localparam int MW = SAMPLE_BITS + 6
)(
    input  wire logic                   clk,
    input  wire logic                   en,
    input  wire logic [MW-1:0]          mag,
    input  wire logic                   neg,
    input  wire logic [CW-1:0]          knee,
    input  wire logic [CW-1:0]          span,
    input  wire logic [CW-1:0]          ceiling,
    output logic [SAMPLE_BITS-1:0]      sample
);

    localparam int SB  = SAMPLE_BITS;
    localparam int DW  = CW + 3;
    localparam int QB  = $clog2(TANH_TABLE_SIZE) + FRAC_W;
    localparam int IB  = QB - FRAC_W;
    localparam int RI  = $clog2(TANH_TABLE_SIZE + 1);
    localparam int XW  = MW + $clog2(TANH_TABLE_SIZE + 1);
    localparam int NW  = XW + FRAC_W;
    localparam int PRW = TANH_W + FRAC_W;
    localparam int STW = CW + TANH_W;

    typedef struct packed {
        logic          neg;
        logic          direct;
        logic [CW-1:0] dval;
        logic [CW-1:0] knee;
        logic [CW-1:0] span;
    } carry_t;

    logic [TANH_W-1:0] rom [TANH_TABLE_SIZE + 1];

    for (genvar g = 0; g <= TANH_TABLE_SIZE; g++)
    begin : g_rom
        localparam logic [TANH_W-1:0] ENT = tanh_entry(64'(g), 64'(TANH_TABLE_SIZE));
        assign rom[g] = ENT;
    end

    // entry: classify and set up division
    logic          pass, sat;
    logic [MW-1:0] over;
    logic [DW-1:0] dd;
    logic [NW-1:0] numer;

    assign pass  = mag <= MW'(knee);
    assign over  = mag - MW'(knee);
    assign dd    = {span, 3'b000};
    assign sat   = (span == '0) || (over >= MW'(dd));
    assign numer = {XW'(over) * XW'(TANH_TABLE_SIZE), {FRAC_W{1'b0}}};

    logic [DW-1:0] rem_reg  [QB+1];
    logic [QB-1:0] nlow_reg [QB+1];
    logic [QB-1:0] q_reg    [QB+1];
    carry_t        cy_reg   [QB+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]     <= numer[QB+DW-1:QB];
            nlow_reg[0]    <= numer[QB-1:0];
            q_reg[0]       <= '0;
            cy_reg[0].neg  <= neg;
            cy_reg[0].direct <= pass || sat;
            cy_reg[0].dval <= pass ? mag[CW-1:0] : ceiling;
            cy_reg[0].knee <= knee;
            cy_reg[0].span <= span;
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < QB; k++)
    begin : g_div
        logic [DW:0]   r2;
        logic [DW-1:0] dk;
        logic          ge;
        assign dk = {cy_reg[k].span, 3'b000};
        assign r2 = {rem_reg[k], nlow_reg[k][QB-1]};
        assign ge = r2 >= (DW+1)'(dk);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= ge ? DW'(r2 - (DW+1)'(dk)) : DW'(r2);
                nlow_reg[k+1] <= {nlow_reg[k][QB-2:0], 1'b0};
                q_reg[k+1]    <= {q_reg[k][QB-2:0], ge};
                cy_reg[k+1]   <= cy_reg[k];
            end
        end
    end

    // table lookup
    logic [IB-1:0]     idx;
    logic              ovr;
    logic [RI-1:0]     ia, ib;
    logic [TANH_W-1:0] lo, hi;
    carry_t            cq;

    assign idx = q_reg[QB][QB-1:FRAC_W];
    assign ovr = RI'(idx) >= RI'(TANH_TABLE_SIZE);
    assign ia  = ovr ? '0 : RI'(idx);
    assign ib  = ia + 1'b1;
    assign lo  = rom[ia];
    assign hi  = rom[ib];

    always_comb
    begin
        cq = cy_reg[QB];
        if (ovr && !cq.direct)
        begin
            cq.direct = 1'b1;
            cq.dval   = cq.knee + cq.span;
        end
    end

    logic [TANH_W-1:0] lo_r_reg, diff_r_reg, lo_m_reg, t_reg;
    logic [FRAC_W-1:0] frac_r_reg;
    logic [PRW-1:0]    prod_m_reg;
    logic [STW-1:0]    st_reg;
    carry_t            cr_reg, cm_reg, ca_reg, cs_reg;
    logic [PRW:0]      pr_rnd;
    logic [STW:0]      st_rnd;
    logic [CW-1:0]     outm;
    logic [SB-1:0]     out_reg;

    assign pr_rnd = {1'b0, prod_m_reg} + (PRW+1)'(64'd1 << (FRAC_W - 1));
    assign st_rnd = {1'b0, st_reg} + (STW+1)'(64'd1 << (TANH_W - 2));
    assign outm   = cs_reg.direct ? cs_reg.dval
                  : CW'(cs_reg.knee + CW'(st_rnd[STW:TANH_W-1]));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_r_reg   <= lo;
            diff_r_reg <= (hi > lo) ? hi - lo : '0;
            frac_r_reg <= q_reg[QB][FRAC_W-1:0];
            cr_reg     <= cq;

            prod_m_reg <= PRW'(diff_r_reg) * PRW'(frac_r_reg);
            lo_m_reg   <= lo_r_reg;
            cm_reg     <= cr_reg;

            t_reg      <= lo_m_reg + TANH_W'(pr_rnd[PRW:FRAC_W]);
            ca_reg     <= cm_reg;

            st_reg     <= STW'(ca_reg.span) * STW'(t_reg);
            cs_reg     <= ca_reg;

            out_reg    <= cs_reg.neg ? SB'(-{1'b0, outm}) : SB'({1'b0, outm});
        end
    end

    assign sample = out_reg;

endmodule
`default_nettype wire

[sv/mbgl_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbgl_back
// Two limiter lanes under one stall, valid and frame marker tracking.
// ----------------------------------------------------------------------------
module mbgl_back
    import mbgl_pkg::*;
#(
    parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
    parameter int TANH_TABLE_SIZE = DEF_TANH_TABLE_SIZE,
    localparam int CW = SAMPLE_BITS - 1,
    localparam int MW = SAMPLE_BITS + 6,
    localparam int PW = 2 * (MW + 1) + 1 + 3 * CW
)(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [PW-1:0]          in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [SAMPLE_BITS-1:0]      left,
    output logic [SAMPLE_BITS-1:0]      right,
    output logic                        last
);

    localparam int LAT = $clog2(TANH_TABLE_SIZE) + FRAC_W + 6;

    logic          en;
    logic          f_last, f_negl, f_negr;
    logic [MW-1:0] f_ml, f_mr;
    logic [CW-1:0] f_knee, f_span, f_ceil;
    logic [LAT-1:0] v_reg, l_reg;

    assign {f_last, f_negl, f_ml, f_negr, f_mr, f_knee, f_span, f_ceil} = in_data;

    assign en       = !v_reg[LAT-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            l_reg <= {l_reg[LAT-2:0], f_last};
    end

    mbgl_lane #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .TANH_TABLE_SIZE (TANH_TABLE_SIZE)
    ) u_lane_l (
        .clk     (clk),
        .en      (en),
        .mag     (f_ml),
        .neg     (f_negl),
        .knee    (f_knee),
        .span    (f_span),
        .ceiling (f_ceil),
        .sample  (left)
    );

    mbgl_lane #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .TANH_TABLE_SIZE (TANH_TABLE_SIZE)
    ) u_lane_r (
        .clk     (clk),
        .en      (en),
        .mag     (f_mr),
        .neg     (f_negr),
        .knee    (f_knee),
        .span    (f_span),
        .ceiling (f_ceil),
        .sample  (right)
    );

    assign out_valid = v_reg[LAT-1];
    assign last      = l_reg[LAT-1];

endmodule
`default_nettype wire

[sv/master_balance_gain_soft_limiter.sv]
`default_nettype none
// Stages: 3 front, 1 queue and ($clog2(TANH_TABLE_SIZE) + 22) back.
// Throughput: one frame per clock while the output is not stalled; the back
// pipeline's one-bit-per-stage divider and table lookup are fully pipelined
// and both channels run in parallel.
// Reset (rst_n low, asynchronous) empties the pipelines and queue and loads
// gain 4096, balance 0 and ceiling all ones; the tanh table is constant.
// ----------------------------------------------------------------------------
// master_balance_gain_soft_limiter
// Stereo master gain and balance followed by a tanh soft knee limiter.
// ----------------------------------------------------------------------------
module master_balance_gain_soft_limiter
    import mbgl_pkg::*;
#(
    parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
    parameter int TANH_TABLE_SIZE = DEF_TANH_TABLE_SIZE,
    localparam int CW    = SAMPLE_BITS - 1,
    localparam int CFG_W = (CW > BAL_W) ? CW : BAL_W
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [CFG_W-1:0]     cfg_data,
    mbgl_in_if.sink                   in_ch,
    mbgl_out_if.source                out_ch
);

    localparam int MW = SAMPLE_BITS + 6;
    localparam int PW = 2 * (MW + 1) + 1 + 3 * CW;

    // configuration registers
    logic [GAIN_W-1:0]        gain_reg;
    logic signed [BAL_W-1:0]  bal_reg;
    logic [CW-1:0]            ceil_reg;
    logic signed [BAL_W-1:0]  bal_wr;
    scale_t                   scale;

    assign bal_wr = $signed(cfg_data[BAL_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
            bal_reg  <= '0;
            ceil_reg <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_e'(cfg_idx))
                CFG_MASTER_GAIN:     gain_reg <= cfg_data[GAIN_W-1:0];
                CFG_MASTER_BALANCE:
                begin
                    // out-of-range balance saturates at full pan
                    if (bal_wr > BAL_MAX)
                        bal_reg <= BAL_MAX;
                    else if (bal_wr < BAL_MIN)
                        bal_reg <= BAL_MIN;
                    else
                        bal_reg <= bal_wr;
                end
                CFG_LIMITER_CEILING: ceil_reg <= cfg_data[CW-1:0];
                default:             ;
            endcase
        end
    end

    // the channel opposite the pan direction is attenuated
    always_comb
    begin
        scale.gain  = gain_reg;
        scale.bal_l = BAL_UNITY;
        scale.bal_r = BAL_UNITY;
        if (bal_reg > 0)
            scale.bal_l = BALF_W'(BAL_UNITY - BALF_W'(bal_reg));
        if (bal_reg < 0)
            scale.bal_r = BALF_W'(BAL_UNITY + BALF_W'(bal_reg));
    end

    // front: magnitude, gain, balance, knee
    logic          fv, fr;
    logic [PW-1:0] fd;

    mbgl_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .left      (in_ch.left_in),
        .right     (in_ch.right_in),
        .last      (in_ch.block_last),
        .scale     (scale),
        .ceiling   (ceil_reg),
        .out_valid (fv),
        .out_ready (fr),
        .out_data  (fd)
    );

    // queue decouples the two stall domains
    logic          qv, qr;
    logic [PW-1:0] qd;

    mbgl_fifo #(
        .W (PW)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fv),
        .wr_ready (fr),
        .wr_data  (fd),
        .rd_valid (qv),
        .rd_ready (qr),
        .rd_data  (qd)
    );

    // back: limiter lanes
    mbgl_back #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .TANH_TABLE_SIZE (TANH_TABLE_SIZE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (qv),
        .in_ready  (qr),
        .in_data   (qd),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .left      (out_ch.left_out),
        .right     (out_ch.right_out),
        .last      (out_ch.block_last_out)
    );

endmodule
`default_nettype wire

[sv/mbgl_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbgl_checker
// Port-level checks: outstanding frames, ceiling bound and output handshake.
// ----------------------------------------------------------------------------
module mbgl_checker
    import mbgl_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int CW    = SAMPLE_BITS - 1,
    localparam int CFG_W = (CW > BAL_W) ? CW : BAL_W
)(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   cfg_we,
    input wire logic [CFG_IDX_W-1:0]   cfg_idx,
    input wire logic [CFG_W-1:0]       cfg_data,
    input wire logic                   in_valid,
    input wire logic                   in_ready,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic [SAMPLE_BITS-1:0] left_out,
    input wire logic [SAMPLE_BITS-1:0] right_out,
    input wire logic                   block_last_out
);

    logic [15:0]   pend_reg;
    logic [CW-1:0] ceil_reg;
    logic [SAMPLE_BITS-1:0] mag_l, mag_r;

    assign mag_l = left_out[SAMPLE_BITS-1]  ? SAMPLE_BITS'(-left_out)  : left_out;
    assign mag_r = right_out[SAMPLE_BITS-1] ? SAMPLE_BITS'(-right_out) : right_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            ceil_reg <= '1;
        end
        else
        begin
            pend_reg <= pend_reg + 16'(in_valid && in_ready) - 16'(out_valid && out_ready);
            if (cfg_we && cfg_idx == CFG_LIMITER_CEILING)
                ceil_reg <= cfg_data[CW-1:0];
        end
    end

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != '0)
        else $error("result without an outstanding frame");

    a_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mag_l <= SAMPLE_BITS'(ceil_reg)) && (mag_r <= SAMPLE_BITS'(ceil_reg)))
        else $error("output magnitude above ceiling");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped while stalled");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(left_out) && $stable(right_out) && $stable(block_last_out))
        else $error("output payload changed while stalled");

endmodule

bind master_balance_gain_soft_limiter mbgl_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_mbgl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .left_out       (out_ch.left_out),
    .right_out      (out_ch.right_out),
    .block_last_out (out_ch.block_last_out)
);
`default_nettype wire
